@@ rtl/core/ptx_pkg.sv @@
package ptx_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;
  localparam int unsigned PW        = 2 * DW;
  localparam int unsigned SUMW      = PW + 2;
  localparam int unsigned RW        = SUMW - FRAC_BITS + 1;
  localparam int unsigned NW        = DW + FRAC_BITS;
  localparam int unsigned QB        = DW + 1;
  localparam int unsigned OW        = DW + 1 + QB;
  localparam int unsigned NREGS     = 8;
  localparam int unsigned IDXW      = $clog2(NREGS);
  localparam int unsigned CFGW      = 2 * DW;

  localparam logic [DW-1:0]   ONE_Q  = DW'(1) << FRAC_BITS;
  localparam logic [SUMW-1:0] HALF_Q = SUMW'(1) << (FRAC_BITS - 1);
  localparam logic [DW-1:0]   MAX_V  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]   MIN_V  = {1'b1, {(DW-1){1'b0}}};

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_DIR   = 1'b1;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          sat;
  } comp_t;

endpackage

@@ rtl/core/ptx_dot.sv @@
module ptx_dot
  import ptx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 use_t_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [DW-1:0] z_i,
  input  logic signed [DW-1:0] m0_i,
  input  logic signed [DW-1:0] m1_i,
  input  logic signed [DW-1:0] m2_i,
  input  logic signed [DW-1:0] t_i,
  output comp_t                res_o
);

  logic signed [PW-1:0]   p0_q, p1_q, p2_q;
  logic signed [SUMW-1:0] sum_q;
  logic                   ut_a_q, ut_b_q;
  logic signed [RW-1:0]   rnd;
  logic signed [RW-1:0]   tr;
  logic                   ovf;
  comp_t                  res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q   <= x_i * m0_i;
      p1_q   <= y_i * m1_i;
      p2_q   <= z_i * m2_i;
      ut_a_q <= use_t_i;
      sum_q  <= SUMW'(p0_q) + SUMW'(p1_q) + SUMW'(p2_q) + $signed(HALF_Q);
      ut_b_q <= ut_a_q;
      res_q  <= res_d;
    end
  end

  // round, add translation, clamp to 32 bits
  always_comb begin
    tr    = ut_b_q ? RW'(t_i) : RW'(0);
    rnd   = RW'(sum_q >>> FRAC_BITS) + tr;
    ovf   = !((&rnd[RW-1:DW-1]) || !(|rnd[RW-1:DW-1]));
    res_d.sat = ovf;
    res_d.val = ovf ? (rnd[RW-1] ? MIN_V : MAX_V) : rnd[DW-1:0];
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/ptx_div.sv @@
module ptx_div
  import ptx_pkg::*;
(
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] x_i,
  input  logic [DW-1:0] w_i,
  input  logic          bypass_i,
  input  logic          sat_i,
  output comp_t         res_o
);

  logic [DW:0]     ax, aw;
  logic [NW-1:0]   n;
  logic            ovf;

  logic [DW-1:0]   rem_q  [QB+1];
  logic [QB-1:0]   q_q    [QB+1];
  logic [QB-1:0]   nlo_q  [QB+1];
  logic [DW-1:0]   d_q    [QB+1];
  logic [DW-1:0]   x_q    [QB+1];
  logic            neg_q  [QB+1];
  logic            ovf_q  [QB+1];
  logic            byp_q  [QB+1];
  logic            sat_q  [QB+1];

  comp_t           res_d, res_q;
  logic [QB-1:0]   qf;
  logic [QB-1:0]   negq;

  always_comb begin
    ax  = x_i[DW-1] ? (DW+1)'(-$signed({x_i[DW-1], x_i})) : {1'b0, x_i};
    aw  = w_i[DW-1] ? (DW+1)'(-$signed({w_i[DW-1], w_i})) : {1'b0, w_i};
    n   = (NW'(ax) << FRAC_BITS) + NW'(aw >> 1);
    ovf = OW'(n) >= (OW'(aw) << QB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(n >> QB);
      q_q[0]   <= '0;
      nlo_q[0] <= n[QB-1:0];
      d_q[0]   <= aw[DW-1:0];
      x_q[0]   <= x_i;
      neg_q[0] <= x_i[DW-1] ^ w_i[DW-1];
      ovf_q[0] <= ovf;
      byp_q[0] <= bypass_i;
      sat_q[0] <= sat_i;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    always_comb begin
      t  = {rem_q[k], nlo_q[k][QB-1-k]};
      ge = t >= {1'b0, d_q[k]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? DW'(t - {1'b0, d_q[k]}) : DW'(t);
        q_q[k+1]   <= {q_q[k][QB-2:0], ge};
        nlo_q[k+1] <= nlo_q[k];
        d_q[k+1]   <= d_q[k];
        x_q[k+1]   <= x_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
        byp_q[k+1] <= byp_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  always_comb begin
    qf   = q_q[QB];
    negq = QB'(0) - qf;
    res_d.sat = sat_q[QB];
    res_d.val = x_q[QB];
    if (!byp_q[QB]) begin
      if (neg_q[QB]) begin
        if (ovf_q[QB] || qf > (QB'(1) << (DW - 1))) begin
          res_d.val = MIN_V;
          res_d.sat = 1'b1;
        end else begin
          res_d.val = negq[DW-1:0];
        end
      end else begin
        if (ovf_q[QB] || (|qf[QB-1:DW-1])) begin
          res_d.val = MAX_V;
          res_d.sat = 1'b1;
        end else begin
          res_d.val = qf[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/point_transform_4x4_top.sv @@
// Homogeneous 4x4 transform of a 3-D row vector in signed Q16.16. Point items
// (command 0) add row 3 and divide x, y, z by the weight w unless w is 0 or
// 1.0; direction items use the upper 3x3 only. One item is taken every cycle
// while no shown result is stalled. The stages in order: one input register,
// three stages of multiply, sum and round/clamp, then setup with rounding, a
// divider stage per quotient bit (33) and a final sign and saturation stage.
// The whole pipeline holds while a shown result is stalled. Write the matrix
// only while the block is empty; it resets to identity.
module point_transform_4x4_top
  import ptx_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDXW-1:0]      cfg_index_i,
  input  logic [CFGW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic signed [DW-1:0] in_x_i,
  input  logic signed [DW-1:0] in_y_i,
  input  logic signed [DW-1:0] in_z_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DW-1:0] out_x_o,
  output logic signed [DW-1:0] out_y_o,
  output logic signed [DW-1:0] out_z_o,
  output logic                 saturated_o
);

  localparam int unsigned LAT = 3 + QB + 2;

  logic [CFGW-1:0]      cfg_q [NREGS];
  logic [LAT:0]         vld_q;
  logic                 cmd_q [4];
  logic signed [DW-1:0] x_q, y_q, z_q;
  logic                 en;
  logic                 bypass;
  comp_t                dx, dy, dz, dw, rx, ry, rz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{CFGW'(ONE_Q), '0, CFGW'(ONE_Q) << DW, '0,
                 '0, CFGW'(ONE_Q), '0, CFGW'(ONE_Q) << DW};
    end else if (cfg_we_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign en         = !vld_q[LAT] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q      <= in_x_i;
      y_q      <= in_y_i;
      z_q      <= in_z_i;
      cmd_q[0] <= command_i;
      cmd_q[1] <= cmd_q[0];
      cmd_q[2] <= cmd_q[1];
      cmd_q[3] <= cmd_q[2];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    comp_t res;
    ptx_dot u_dot (
      .clk_i   (clk_i),
      .en_i    (en),
      .use_t_i ((c == 3) ? 1'b1 : (cmd_q[0] == CMD_POINT)),
      .x_i     (x_q),
      .y_i     (y_q),
      .z_i     (z_q),
      .m0_i    (cfg_q[c >> 1][DW*(c & 1) +: DW]),
      .m1_i    (cfg_q[2 + (c >> 1)][DW*(c & 1) +: DW]),
      .m2_i    (cfg_q[4 + (c >> 1)][DW*(c & 1) +: DW]),
      .t_i     (cfg_q[6 + (c >> 1)][DW*(c & 1) +: DW]),
      .res_o   (res)
    );
  end

  assign dx = g_col[0].res;
  assign dy = g_col[1].res;
  assign dz = g_col[2].res;
  assign dw = g_col[3].res;

  // skip the divide for directions and for a weight of 0 or 1.0
  assign bypass = (cmd_q[3] == CMD_DIR) || (dw.val == '0) || (dw.val == ONE_Q);

  ptx_div u_div_x (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (dx.val),
    .w_i      (dw.val),
    .bypass_i (bypass),
    .sat_i    (dx.sat || ((cmd_q[3] == CMD_POINT) && dw.sat)),
    .res_o    (rx)
  );

  ptx_div u_div_y (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (dy.val),
    .w_i      (dw.val),
    .bypass_i (bypass),
    .sat_i    (dy.sat),
    .res_o    (ry)
  );

  ptx_div u_div_z (
    .clk_i    (clk_i),
    .en_i     (en),
    .x_i      (dz.val),
    .w_i      (dw.val),
    .bypass_i (bypass),
    .sat_i    (dz.sat),
    .res_o    (rz)
  );

  assign out_valid_o = vld_q[LAT];
  assign out_x_o     = rx.val;
  assign out_y_o     = ry.val;
  assign out_z_o     = rz.val;
  assign saturated_o = rx.sat || ry.sat || rz.sat;

  a_hold_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid pipeline moved while stalled");

  a_stall_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while the output was held");

endmodule
